// ===== rtl/core/sxfb_pkg.sv =====
package sxfb_pkg;

	// Default screen geometry
	localparam int DEF_WIDTH  = 64;
	localparam int DEF_HEIGHT = 32;

	// Field widths of the item and result channels
	localparam int KIND_W   = 2;
	localparam int X_W      = 6;
	localparam int Y_W      = 5;
	localparam int OFF_W    = 4;
	localparam int SPRITE_W = 8;
	localparam int PIX_W    = 64;

	// Target row: start row (below 32) plus row offset (below 16)
	localparam int TGT_W = 7;

	// Item kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_CLEAR = 2'd0,
		KIND_DRAW  = 2'd1,
		KIND_SET   = 2'd2,
		KIND_READ  = 2'd3
	} kind_t;

	// Control broadcast to every column lane
	typedef struct packed {
		logic                draw_en;
		logic                set_en;
		logic [X_W-1:0]      col0;
		logic [X_W-1:0]      x;
		logic [SPRITE_W-1:0] sprite;
	} lane_ctl_t;

endpackage

// ===== rtl/core/sxfb_lane.sv =====
module sxfb_lane #(
	parameter int COL = 0
) (
	input  sxfb_pkg::lane_ctl_t ctl,
	input  logic                old_bit,
	output logic                new_bit,
	output logic                hit
);
	import sxfb_pkg::*;

	logic [X_W:0] diff;
	logic         in_win;
	logic         pix;

	// Locate this column inside the eight-pixel sprite window
	assign diff   = (X_W + 1)'(COL) - {1'b0, ctl.col0};
	assign in_win = !diff[X_W] && (diff[X_W-1:3] == '0);
	assign pix    = ctl.draw_en && in_win && ctl.sprite[~diff[2:0]];

	// XOR the sprite pixel in, light the pixel on a set, flag an erased lit pixel
	assign hit     = pix && old_bit;
	assign new_bit = (old_bit ^ pix) | (ctl.set_en && (ctl.x == X_W'(COL)));

endmodule

// ===== rtl/core/sxfb_merge.sv =====
module sxfb_merge #(
	parameter int WIDTH = sxfb_pkg::DEF_WIDTH
) (
	input  logic [WIDTH-1:0]           hit_vec,
	input  logic [WIDTH-1:0]           old_row,
	input  logic                       read_en,
	output logic                       hit_any,
	output logic [sxfb_pkg::PIX_W-1:0] pixels
);
	import sxfb_pkg::*;

	// Combine lane collisions and form the read word
	assign hit_any = |hit_vec;
	assign pixels  = read_en ? PIX_W'(old_row) : '0;

endmodule

// ===== rtl/core/sprite_xor_framebuffer_unit.sv =====
// One-bit framebuffer of SCREEN_WIDTH columns by SCREEN_HEIGHT rows with XOR
// sprite drawing. Each transaction on the input channel (clear frame, draw one
// sprite row, set one pixel, read one row) yields exactly one transaction on
// the output channel carrying the collision flag, sprite_done and row_pixels.
// The row is read from the single-port frame memory when an item is accepted
// and, for a draw or a set, written back when the item completes, where one
// lane per column computes the new pixel and the lane collisions are ORed
// together; the next item is taken once the last one has completed. A
// finished result sits in an output register, so a stall on the output only
// holds the block when a second result is ready before the first has left.
// Row valid bits drop on reset and on a clear-frame item, so no clearing pass
// is needed. Draw pixels beyond the right or bottom edge are dropped.
module sprite_xor_framebuffer_unit #(
	parameter int SCREEN_WIDTH  = sxfb_pkg::DEF_WIDTH,
	parameter int SCREEN_HEIGHT = sxfb_pkg::DEF_HEIGHT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [sxfb_pkg::KIND_W-1:0]   kind,
	input  logic [sxfb_pkg::X_W-1:0]      x,
	input  logic [sxfb_pkg::Y_W-1:0]      y,
	input  logic [sxfb_pkg::OFF_W-1:0]    row_offset,
	input  logic [sxfb_pkg::SPRITE_W-1:0] sprite_row,
	input  logic                          last_row,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          collision,
	output logic                          sprite_done,
	output logic [sxfb_pkg::PIX_W-1:0]    row_pixels
);
	import sxfb_pkg::*;

	localparam int ROW_AW = $clog2(SCREEN_HEIGHT);

	logic                    accept;
	logic [X_W-1:0]          x_mod;
	logic [Y_W-1:0]          y_mod;
	logic [TGT_W-1:0]        tgt;
	logic                    tgt_ok;
	logic                    x_ok;

	logic                    valid_s1;
	kind_t                   kind_s1;
	logic [X_W-1:0]          col0_s1;
	logic [X_W-1:0]          x_s1;
	logic [ROW_AW-1:0]       addr_s1;
	logic                    ok_s1;
	logic                    set_ok_s1;
	logic [SPRITE_W-1:0]     sprite_s1;
	logic                    last_s1;
	logic                    off_zero_s1;
	logic [SCREEN_WIDTH-1:0] rd_s1;

	logic [SCREEN_WIDTH-1:0] frame_mem [SCREEN_HEIGHT];
	logic [SCREEN_HEIGHT-1:0] row_vld_q;
	logic                    flag_q;

	logic                    complete;
	logic [SCREEN_WIDTH-1:0] old_row;
	logic [SCREEN_WIDTH-1:0] new_row;
	logic [SCREEN_WIDTH-1:0] hit_vec;
	lane_ctl_t               ctl;
	logic                    read_en;
	logic                    wr_en;
	logic                    hit_any;
	logic [PIX_W-1:0]        pixels;
	logic                    flag_next;

	logic                    out_valid_q;
	logic                    collision_q;
	logic                    done_q;
	logic [PIX_W-1:0]        pixels_q;

	// Hold the input while an item is in the write stage
	assign in_stall = valid_s1;
	assign accept   = in_valid && !in_stall;

	// Wrap the start column and start row by repeated subtraction
	always_comb begin
		x_mod = x;
		y_mod = y;
		for (int i = 0; i < 8; i++) begin
			if ({1'b0, x_mod} >= (X_W + 1)'(SCREEN_WIDTH))
				x_mod = x_mod - X_W'(SCREEN_WIDTH);
			if ({2'b0, y_mod} >= (Y_W + 2)'(SCREEN_HEIGHT))
				y_mod = y_mod - Y_W'(SCREEN_HEIGHT);
		end
	end

	// Pick the target row and check it against the screen
	always_comb begin
		if (kind_t'(kind) == KIND_DRAW)
			tgt = TGT_W'(y_mod) + TGT_W'(row_offset);
		else
			tgt = TGT_W'(y);
		tgt_ok = tgt < TGT_W'(SCREEN_HEIGHT);
		x_ok   = {1'b0, x} < (X_W + 1)'(SCREEN_WIDTH);
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (complete) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1     <= kind_t'(kind);
			col0_s1     <= x_mod;
			x_s1        <= x;
			addr_s1     <= tgt[ROW_AW-1:0];
			ok_s1       <= tgt_ok;
			set_ok_s1   <= tgt_ok && x_ok;
			sprite_s1   <= sprite_row;
			last_s1     <= last_row;
			off_zero_s1 <= (row_offset == '0);
		end
	end

	// Frame memory read
	always_ff @(posedge clk) begin
		if (accept)
			rd_s1 <= frame_mem[tgt[ROW_AW-1:0]];
	end

	// Frame memory write
	always_ff @(posedge clk) begin
		if (wr_en)
			frame_mem[addr_s1] <= new_row;
	end

	// Finish the item once the output register is free
	assign complete = valid_s1 && (!out_valid_q || !out_stall);
	assign old_row  = row_vld_q[addr_s1] ? rd_s1 : '0;
	assign read_en  = (kind_s1 == KIND_READ) && ok_s1;

	always_comb begin
		ctl.draw_en = (kind_s1 == KIND_DRAW) && ok_s1;
		ctl.set_en  = (kind_s1 == KIND_SET) && set_ok_s1;
		ctl.col0    = col0_s1;
		ctl.x       = x_s1;
		ctl.sprite  = sprite_s1;
	end

	assign wr_en = complete && (ctl.draw_en || ctl.set_en);

	// One lane per column
	for (genvar g = 0; g < SCREEN_WIDTH; g++) begin : g_lane
		sxfb_lane #(
			.COL(g)
		) u_lane (
			.ctl    (ctl),
			.old_bit(old_row[g]),
			.new_bit(new_row[g]),
			.hit    (hit_vec[g])
		);
	end

	sxfb_merge #(
		.WIDTH(SCREEN_WIDTH)
	) u_merge (
		.hit_vec(hit_vec),
		.old_row(old_row),
		.read_en(read_en),
		.hit_any(hit_any),
		.pixels (pixels)
	);

	// Clear the flag at a new sprite, set it on an erased pixel
	always_comb begin
		flag_next = flag_q;
		if (kind_s1 == KIND_DRAW)
			flag_next = (flag_q && !off_zero_s1) || hit_any;
	end

	// Row valid bits and collision flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			flag_q    <= 1'b0;
		end else if (complete) begin
			flag_q <= flag_next;
			if (kind_s1 == KIND_CLEAR)
				row_vld_q <= '0;
			else if (wr_en)
				row_vld_q[addr_s1] <= 1'b1;
		end
	end

	// Output transaction control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (complete) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (complete) begin
			collision_q <= flag_next;
			done_q      <= (kind_s1 == KIND_DRAW) && last_s1;
			pixels_q    <= pixels;
		end
	end

	assign out_valid   = out_valid_q;
	assign collision   = collision_q;
	assign sprite_done = done_q;
	assign row_pixels  = pixels_q;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import sxfb_pkg::*;

	localparam int SCREEN_W = DEF_WIDTH;
	localparam int SCREEN_H = DEF_HEIGHT;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic             collision;
		logic             sprite_done;
		logic [PIX_W-1:0] row_pixels;
	} fb_result_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [KIND_W-1:0] kind;
	logic [X_W-1:0] x;
	logic [Y_W-1:0] y;
	logic [OFF_W-1:0] row_offset;
	logic [SPRITE_W-1:0] sprite_row;
	logic last_row;
	logic out_valid;
	logic out_stall;
	logic collision;
	logic sprite_done;
	logic [PIX_W-1:0] row_pixels;

	// Shadow copy of the frame and collision flag
	logic [PIX_W-1:0] fb_rows [SCREEN_H];
	logic fb_collision;

	fb_result_t pending_results[$];
	int errors;
	int items_sent;
	int sender_idle_pct;
	int receiver_stall_pct;
	int hold_req;
	int hold_left;
	int quiet_cycles;

	sprite_xor_framebuffer_unit #(
		.SCREEN_WIDTH(SCREEN_W),
		.SCREEN_HEIGHT(SCREEN_H)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.x(x),
		.y(y),
		.row_offset(row_offset),
		.sprite_row(sprite_row),
		.last_row(last_row),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.collision(collision),
		.sprite_done(sprite_done),
		.row_pixels(row_pixels)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Apply one transaction to the shadow frame and return its result
	function automatic fb_result_t predict_framebuffer(kind_t k, logic [X_W-1:0] px,
			logic [Y_W-1:0] py, logic [OFF_W-1:0] off, logic [SPRITE_W-1:0] spr,
			logic last);
		fb_result_t r;
		logic [PIX_W-1:0] pattern;
		int target;
		int col0;
		r = '0;
		pattern = '0;
		col0 = int'(px) % SCREEN_W;
		target = int'(py) % SCREEN_H + int'(off);
		case (k)
			KIND_CLEAR: begin
				for (int i = 0; i < SCREEN_H; i++)
					fb_rows[i] = '0;
			end
			KIND_DRAW: begin
				if (off == 0)
					fb_collision = 1'b0;
				// drop pixels past the right edge and rows past the bottom
				if (target < SCREEN_H) begin
					for (int i = 0; i < SPRITE_W; i++)
						if (spr[SPRITE_W-1-i] && col0 + i < SCREEN_W)
							pattern[col0+i] = 1'b1;
					if ((fb_rows[target] & pattern) != '0)
						fb_collision = 1'b1;
					fb_rows[target] ^= pattern;
				end
				r.sprite_done = last;
			end
			KIND_SET: begin
				if (int'(px) < SCREEN_W && int'(py) < SCREEN_H)
					fb_rows[py][px] = 1'b1;
			end
			default: begin
				if (int'(py) < SCREEN_H)
					r.row_pixels = fb_rows[py];
			end
		endcase
		r.collision = fb_collision;
		return r;
	endfunction

	// Offer one item, hold it until accepted, then record the expected result
	task automatic send_item(kind_t k, logic [X_W-1:0] px, logic [Y_W-1:0] py,
			logic [OFF_W-1:0] off, logic [SPRITE_W-1:0] spr, logic last);
		if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		in_valid <= 1'b1;
		kind <= k;
		x <= px;
		y <= py;
		row_offset <= off;
		sprite_row <= spr;
		last_row <= last;
		do @(posedge clk); while (in_stall !== 1'b0);
		pending_results.push_back(predict_framebuffer(k, px, py, off, spr, last));
		items_sent++;
	endtask

	// Stop offering and wait for every outstanding result
	task automatic wait_until_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// Draw a well-formed sprite: offsets 0..n-1, last row marked
	task automatic send_sprite(int n_rows, logic [X_W-1:0] px, logic [Y_W-1:0] py);
		for (int r = 0; r < n_rows; r++)
			send_item(KIND_DRAW, px, py, OFF_W'(r), SPRITE_W'($urandom_range(255)),
				r == n_rows - 1);
	endtask

	// Mix of sprites, reads, pixel sets, clears and malformed draws
	task automatic run_random_items(int n_items);
		int stop_at;
		int pick;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 55)
				send_sprite($urandom_range(1, 15), X_W'($urandom_range(63)),
					Y_W'($urandom_range(31)));
			else if (pick < 75)
				send_item(KIND_READ, X_W'($urandom_range(63)), Y_W'($urandom_range(31)),
					OFF_W'($urandom_range(15)), SPRITE_W'($urandom_range(255)),
					1'($urandom_range(1)));
			else if (pick < 87)
				send_item(KIND_SET, X_W'($urandom_range(63)), Y_W'($urandom_range(31)),
					OFF_W'($urandom_range(15)), SPRITE_W'($urandom_range(255)),
					1'($urandom_range(1)));
			else if (pick < 90)
				send_item(KIND_CLEAR, X_W'($urandom_range(63)), Y_W'($urandom_range(31)),
					OFF_W'($urandom_range(15)), SPRITE_W'($urandom_range(255)),
					1'($urandom_range(1)));
			else
				send_item(KIND_DRAW, X_W'($urandom_range(63)), Y_W'($urandom_range(31)),
					OFF_W'($urandom_range(15)), SPRITE_W'($urandom_range(255)),
					1'($urandom_range(1)));
		end
	endtask

	task automatic test_directed();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		send_item(KIND_READ, 6'd0, 5'd0, 4'd0, 8'h00, 1'b0);
		send_item(KIND_SET, 6'd0, 5'd0, 4'd15, 8'hff, 1'b1);
		send_item(KIND_SET, 6'd63, 5'd31, 4'd0, 8'h00, 1'b0);
		send_item(KIND_SET, 6'd63, 5'd0, 4'd0, 8'h00, 1'b0);
		send_item(KIND_READ, 6'd63, 5'd0, 4'd0, 8'h00, 1'b0);
		send_item(KIND_READ, 6'd0, 5'd31, 4'd0, 8'h00, 1'b0);
		// overlap a lit pixel to raise the collision flag
		send_item(KIND_DRAW, 6'd0, 5'd0, 4'd0, 8'hff, 1'b0);
		send_item(KIND_DRAW, 6'd0, 5'd0, 4'd1, 8'h81, 1'b1);
		// clear frame keeps the flag
		send_item(KIND_CLEAR, 6'd0, 5'd0, 4'd0, 8'h00, 1'b0);
		send_item(KIND_READ, 6'd0, 5'd0, 4'd0, 8'h00, 1'b0);
		// right edge clipping
		send_item(KIND_DRAW, 6'd60, 5'd5, 4'd0, 8'hff, 1'b1);
		send_item(KIND_READ, 6'd0, 5'd5, 4'd0, 8'h00, 1'b0);
		send_item(KIND_DRAW, 6'd63, 5'd6, 4'd0, 8'h80, 1'b0);
		send_item(KIND_DRAW, 6'd63, 5'd6, 4'd1, 8'h7f, 1'b1);
		send_item(KIND_READ, 6'd0, 5'd6, 4'd0, 8'h00, 1'b0);
		// bottom edge clipping, with and without a new sprite
		send_item(KIND_DRAW, 6'd10, 5'd31, 4'd1, 8'haa, 1'b0);
		send_item(KIND_DRAW, 6'd10, 5'd31, 4'd15, 8'hff, 1'b1);
		send_item(KIND_DRAW, 6'd5, 5'd31, 4'd0, 8'h55, 1'b0);
		send_item(KIND_DRAW, 6'd5, 5'd31, 4'd0, 8'h55, 1'b1);
		send_item(KIND_DRAW, 6'd40, 5'd20, 4'd1, 8'h55, 1'b0);
		send_item(KIND_DRAW, 6'd40, 5'd31, 4'd0, 8'h00, 1'b1);
		send_item(KIND_READ, 6'd0, 5'd31, 4'd0, 8'h00, 1'b0);
		send_item(KIND_READ, 6'd0, 5'd21, 4'd0, 8'h00, 1'b0);
		wait_until_drained();
	endtask

	task automatic test_no_idle();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		run_random_items(100);
		wait_until_drained();
	endtask

	task automatic test_sender_idle();
		sender_idle_pct = 78;
		receiver_stall_pct = 0;
		run_random_items(100);
		wait_until_drained();
	endtask

	task automatic test_receiver_stall();
		sender_idle_pct = 0;
		receiver_stall_pct = 78;
		run_random_items(100);
		wait_until_drained();
	endtask

	task automatic test_both_idle();
		sender_idle_pct = 19;
		receiver_stall_pct = 19;
		run_random_items(100);
		wait_until_drained();
	endtask

	// Block the output for a long stretch while items keep coming
	task automatic test_output_hold();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		hold_req = HOLD_CYCLES;
		run_random_items(40);
		wait_until_drained();
	endtask

	// Reset once, then run the tests in turn
	initial begin
		errors = 0;
		items_sent = 0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		hold_req = 0;
		fb_collision = 1'b0;
		for (int i = 0; i < SCREEN_H; i++)
			fb_rows[i] = '0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		kind <= KIND_CLEAR;
		x <= '0;
		y <= '0;
		row_offset <= '0;
		sprite_row <= '0;
		last_row <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_no_idle();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		test_output_hold();
		test_no_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			errors += pending_results.size();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Drive output stall: long hold on request, random otherwise
	initial begin
		out_stall <= 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < receiver_stall_pct);
			end
		end
	end

	// Compare each output transaction with the oldest expected result
	always @(posedge clk) begin
		fb_result_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: collision=%0b done=%0b pixels=%h",
						collision, sprite_done, row_pixels);
			end else begin
				want = pending_results.pop_front();
				if (collision !== want.collision || sprite_done !== want.sprite_done ||
						row_pixels !== want.row_pixels) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: collision %0b/%0b done %0b/%0b pixels %h/%h",
							want.collision, collision, want.sprite_done, sprite_done,
							want.row_pixels, row_pixels);
				end
			end
		end
	end

	// Abort if neither channel moves a transaction for too long
	always @(posedge clk) begin
		if ((in_valid === 1'b1 && in_stall === 1'b0) ||
				(out_valid === 1'b1 && out_stall === 1'b0))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial quiet_cycles = 0;

endmodule
